>>> hw/rtl/spi_nand_read_sequencer_assert.svh
// Assertion macros shared by the checker files of the SPI NAND read sequencer.
// No dependencies; expects clk and rst in the scope of each use.
`ifndef SPI_NAND_READ_SEQUENCER_ASSERT_SVH
`define SPI_NAND_READ_SEQUENCER_ASSERT_SVH

// same-cycle implication
`define SNRS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SNRS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/snrs_pkg.sv
// Package of the SPI NAND read sequencer: codes, job and result types,
// and the job expansion function used by the back end. No dependencies.
package snrs_pkg;

  localparam int ADDRESS_BITS = 32;
  typedef logic [ADDRESS_BITS-1:0] addr_t;

  localparam logic [3:0] PAGE_SHIFT_RESET = 4'd11;
  localparam logic [3:0] PAGE_SHIFT_MIN   = 4'd9;
  localparam logic [3:0] PAGE_SHIFT_MAX   = 4'd14;

  // input word kinds
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_RX    = 1'b1;

  // result actions
  localparam logic [2:0] ACT_TX       = 3'd0;
  localparam logic [2:0] ACT_CLOCK    = 3'd1;
  localparam logic [2:0] ACT_DESELECT = 3'd2;
  localparam logic [2:0] ACT_DATA     = 3'd3;
  localparam logic [2:0] ACT_DONE     = 3'd4;

  // flash opcodes and fixed bytes
  localparam logic [7:0] OP_PAGE_READ   = 8'h13;
  localparam logic [7:0] OP_READ_CACHE  = 8'h03;
  localparam logic [7:0] OP_GET_FEATURE = 8'h0f;
  localparam logic [7:0] FEAT_STATUS    = 8'hc0;
  localparam logic [7:0] FILL_BYTE      = 8'hff;
  localparam logic [7:0] DUMMY_BYTE     = 8'h00;

  // job kinds passed from front to back
  localparam logic [2:0] K_DONE       = 3'd0; // done(data)
  localparam logic [2:0] K_PIECE      = 3'd1; // page read frame + poll
  localparam logic [2:0] K_TAIL_PIECE = 3'd2; // deselect + page read frame + poll
  localparam logic [2:0] K_POLL       = 3'd3; // deselect + poll
  localparam logic [2:0] K_READ       = 3'd4; // deselect + read-from-cache frame
  localparam logic [2:0] K_DCONT      = 3'd5; // data + clock
  localparam logic [2:0] K_DEND       = 3'd6; // data + deselect + poll
  localparam logic [2:0] K_TAIL_DONE  = 3'd7; // deselect + done(data)

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] data;
  } job_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  tx_byte;
    logic [7:0]  data_byte;
    logic [31:0] bytes_done;
    logic        last;
  } res_t;

  function automatic res_t mk_res(logic [2:0] act, logic [7:0] tx, logic [7:0] db,
                                  logic [31:0] dn, logic lst);
    res_t r;
    r.action     = act;
    r.tx_byte    = tx;
    r.data_byte  = db;
    r.bytes_done = dn;
    r.last       = lst;
    return r;
  endfunction

  // deselect, get-feature, status address, clock in
  function automatic res_t poll_res(logic [1:0] s);
    res_t r;
    case (s)
      2'd0:    r = mk_res(ACT_DESELECT, 8'h00, 8'h00, 32'd0, 1'b0);
      2'd1:    r = mk_res(ACT_TX, OP_GET_FEATURE, 8'h00, 32'd0, 1'b0);
      2'd2:    r = mk_res(ACT_TX, FEAT_STATUS, 8'h00, 32'd0, 1'b0);
      default: r = mk_res(ACT_CLOCK, FILL_BYTE, 8'h00, 32'd0, 1'b1);
    endcase
    return r;
  endfunction

  // page-to-cache frame then a poll; d holds the page address
  function automatic res_t piece_res(logic [2:0] s, logic [31:0] d);
    res_t r;
    case (s)
      3'd0:    r = mk_res(ACT_TX, OP_PAGE_READ, 8'h00, 32'd0, 1'b0);
      3'd1:    r = mk_res(ACT_TX, d[23:16], 8'h00, 32'd0, 1'b0);
      3'd2:    r = mk_res(ACT_TX, d[15:8], 8'h00, 32'd0, 1'b0);
      3'd3:    r = mk_res(ACT_TX, d[7:0], 8'h00, 32'd0, 1'b0);
      default: r = poll_res(2'(s - 3'd4));
    endcase
    return r;
  endfunction

  function automatic res_t job_result(logic [2:0] kind, logic [3:0] step, logic [31:0] d);
    res_t r;
    r = mk_res(ACT_DONE, 8'h00, 8'h00, d, 1'b1);
    unique case (kind)
      K_DONE:  r = mk_res(ACT_DONE, 8'h00, 8'h00, d, 1'b1);
      K_PIECE: r = piece_res(step[2:0], d);
      K_TAIL_PIECE: begin
        if (step == 4'd0) r = mk_res(ACT_DESELECT, 8'h00, 8'h00, 32'd0, 1'b0);
        else              r = piece_res(3'(step - 4'd1), d);
      end
      K_POLL:  r = poll_res(step[1:0]);
      K_READ: begin
        case (step)
          4'd0:    r = mk_res(ACT_DESELECT, 8'h00, 8'h00, 32'd0, 1'b0);
          4'd1:    r = mk_res(ACT_TX, OP_READ_CACHE, 8'h00, 32'd0, 1'b0);
          4'd2:    r = mk_res(ACT_TX, d[15:8], 8'h00, 32'd0, 1'b0);
          4'd3:    r = mk_res(ACT_TX, d[7:0], 8'h00, 32'd0, 1'b0);
          4'd4:    r = mk_res(ACT_TX, DUMMY_BYTE, 8'h00, 32'd0, 1'b0);
          default: r = mk_res(ACT_CLOCK, FILL_BYTE, 8'h00, 32'd0, 1'b1);
        endcase
      end
      K_DCONT: begin
        if (step == 4'd0) r = mk_res(ACT_DATA, 8'h00, d[7:0], 32'd0, 1'b0);
        else              r = mk_res(ACT_CLOCK, FILL_BYTE, 8'h00, 32'd0, 1'b1);
      end
      K_DEND: begin
        if (step == 4'd0) r = mk_res(ACT_DATA, 8'h00, d[7:0], 32'd0, 1'b0);
        else              r = poll_res(2'(step - 4'd1));
      end
      K_TAIL_DONE: begin
        if (step == 4'd0) r = mk_res(ACT_DESELECT, 8'h00, 8'h00, 32'd0, 1'b0);
        else              r = mk_res(ACT_DONE, 8'h00, 8'h00, d, 1'b1);
      end
      default: r = mk_res(ACT_DONE, 8'h00, 8'h00, d, 1'b1);
    endcase
    return r;
  endfunction

endpackage

>>> hw/rtl/snrs_front.sv
// Front end: accepts input words, tracks the read state, emits at most one job per word.
// Depends on snrs_pkg.
module snrs_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [71:0]        s_tdata,   // start_offset[31:0], byte_count[63:32], rx_byte[71:64]
  input  logic               s_tuser,   // command
  input  logic [3:0]         page_shift,
  output logic               q_push,
  output snrs_pkg::job_t     q_job,
  input  logic               q_full
);

  localparam logic [1:0] PH_IDLE      = 2'd0;
  localparam logic [1:0] PH_POLL_LOAD = 2'd1;
  localparam logic [1:0] PH_DATA      = 2'd2;
  localparam logic [1:0] PH_POLL_TAIL = 2'd3;

  logic [1:0]            phase, phase_next;
  snrs_pkg::addr_t       next_address, next_address_next;
  logic [31:0]           bytes_left, bytes_left_next;
  logic [31:0]           bytes_delivered, bytes_delivered_next;
  logic [14:0]           piece_left, piece_left_next;

  logic                  accept, is_start;
  logic [31:0]           in_offset, in_count;
  logic [7:0]            rx;
  logic [3:0]            sh;
  snrs_pkg::addr_t       src_addr;
  logic [31:0]           src_left, addr_ext, pa;
  logic [15:0]           psize, room;
  logic [14:0]           col, piece, pl_dec;
  logic [31:0]           bl_dec;

  assign s_tready  = !q_full;
  assign accept    = s_tvalid && s_tready;
  assign is_start  = (s_tuser == snrs_pkg::CMD_START);
  assign in_offset = s_tdata[31:0];
  assign in_count  = s_tdata[63:32];
  assign rx        = s_tdata[71:64];

  always_comb begin
    if (page_shift < snrs_pkg::PAGE_SHIFT_MIN)      sh = snrs_pkg::PAGE_SHIFT_MIN;
    else if (page_shift > snrs_pkg::PAGE_SHIFT_MAX) sh = snrs_pkg::PAGE_SHIFT_MAX;
    else                                            sh = page_shift;
  end

  // piece geometry on either the new start range or the running address
  assign src_addr = is_start ? in_offset[snrs_pkg::ADDRESS_BITS-1:0] : next_address;
  assign src_left = is_start ? in_count : bytes_left;
  assign addr_ext = 32'(src_addr);
  assign psize    = 16'd1 << sh;
  assign col      = addr_ext[14:0] & 15'(psize - 16'd1);
  assign room     = psize - {1'b0, col};
  assign piece    = (src_left < 32'(room)) ? src_left[14:0] : room[14:0];
  assign pa       = addr_ext >> sh;
  assign pl_dec   = piece_left - 15'd1;
  assign bl_dec   = bytes_left - 32'd1;

  always_comb begin
    phase_next           = phase;
    next_address_next    = next_address;
    bytes_left_next      = bytes_left;
    bytes_delivered_next = bytes_delivered;
    piece_left_next      = piece_left;
    q_push               = 1'b0;
    q_job.kind           = snrs_pkg::K_DONE;
    q_job.data           = 32'd0;
    if (accept) begin
      if (is_start) begin
        next_address_next    = src_addr;
        bytes_left_next      = in_count;
        bytes_delivered_next = 32'd0;
        q_push               = 1'b1;
        if (in_count == 32'd0) begin
          piece_left_next = 15'd0;
          phase_next      = PH_IDLE;
        end else begin
          piece_left_next = piece;
          q_job.kind      = snrs_pkg::K_PIECE;
          q_job.data      = {8'd0, pa[23:0]};
          phase_next      = PH_POLL_LOAD;
        end
      end else begin
        unique case (phase)
          PH_POLL_LOAD: begin
            q_push = 1'b1;
            if (rx[0]) begin
              q_job.kind = snrs_pkg::K_POLL;
            end else begin
              q_job.kind = snrs_pkg::K_READ;
              q_job.data = 32'(col);
              phase_next = PH_DATA;
            end
          end
          PH_DATA: begin
            q_push               = 1'b1;
            q_job.data           = {24'd0, rx};
            next_address_next    = next_address + snrs_pkg::addr_t'(1);
            bytes_left_next      = bl_dec;
            bytes_delivered_next = bytes_delivered + 32'd1;
            if (pl_dec != 15'd0 && bl_dec != 32'd0) begin
              piece_left_next = pl_dec;
              q_job.kind      = snrs_pkg::K_DCONT;
            end else begin
              piece_left_next = 15'd0;
              q_job.kind      = snrs_pkg::K_DEND;
              phase_next      = PH_POLL_TAIL;
            end
          end
          PH_POLL_TAIL: begin
            q_push = 1'b1;
            if (rx[0]) begin
              q_job.kind = snrs_pkg::K_POLL;
            end else if (bytes_left != 32'd0) begin
              piece_left_next = piece;
              q_job.kind      = snrs_pkg::K_TAIL_PIECE;
              q_job.data      = {8'd0, pa[23:0]};
              phase_next      = PH_POLL_LOAD;
            end else begin
              q_job.kind = snrs_pkg::K_TAIL_DONE;
              q_job.data = bytes_delivered;
              phase_next = PH_IDLE;
            end
          end
          default: ; // idle: stray byte ignored
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      next_address    <= '0;
      bytes_left      <= 32'd0;
      bytes_delivered <= 32'd0;
      piece_left      <= 15'd0;
    end else begin
      phase           <= phase_next;
      next_address    <= next_address_next;
      bytes_left      <= bytes_left_next;
      bytes_delivered <= bytes_delivered_next;
      piece_left      <= piece_left_next;
    end
  end

endmodule

>>> hw/rtl/snrs_queue.sv
// Four-entry job queue between front and back ends.
// Depends on snrs_pkg.
module snrs_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  snrs_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           q_valid,
  output snrs_pkg::job_t q_job
);

  snrs_pkg::job_t entries [4];
  logic [1:0]     wr_ptr, rd_ptr;
  logic [2:0]     count;

  assign full    = (count == 3'd4);
  assign q_valid = (count != 3'd0);
  assign q_job   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count  <= 3'd0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 2'd1;
      if (pop)  rd_ptr <= rd_ptr + 2'd1;
      count <= count + 3'(push) - 3'(pop);
    end
  end

endmodule

>>> hw/rtl/snrs_back.sv
// Back end: expands one job at a time into result words, one per cycle while the
// output is not stalled, through a registered output stage. Depends on snrs_pkg.
module snrs_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  snrs_pkg::job_t q_job,
  output logic           pop,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [47:0]    m_tdata,  // tx_byte[7:0], data_byte[15:8], bytes_done[47:16]
  output logic [2:0]     m_tuser,  // action
  output logic           m_tlast
);

  logic           cur_valid;
  snrs_pkg::job_t cur;
  logic [3:0]     step;
  snrs_pkg::res_t res;
  logic           out_free, emit;

  assign res      = snrs_pkg::job_result(cur.kind, step, cur.data);
  assign out_free = !m_tvalid || m_tready;
  assign emit     = cur_valid && out_free;
  assign pop      = q_valid && (!cur_valid || (emit && res.last));

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      if (pop)                cur_valid <= 1'b1;
      else if (emit && res.last) cur_valid <= 1'b0;
      if (out_free) m_tvalid <= cur_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur  <= q_job;
      step <= 4'd0;
    end else if (emit) begin
      step <= step + 4'd1;
    end
    if (emit) begin
      m_tdata <= {res.bytes_done, res.data_byte, res.tx_byte};
      m_tuser <= res.action;
      m_tlast <= res.last;
    end
  end

endmodule

>>> hw/rtl/spi_nand_read_sequencer.sv
// SPI NAND read sequencer top level: APB page size register, front end,
// job queue and back end. Depends on snrs_pkg, snrs_front, snrs_queue, snrs_back.
//
// Usage:
//   Input stream (s_*): s_tuser is the command (0 start, 1 byte received).
//   A start carries start_offset and byte_count; a received byte carries
//   rx_byte. Output stream (m_*): m_tuser is the action (send, clock in,
//   deselect, data to host, finished), m_tlast marks the final word caused
//   by one input word.
//   Each input word expands to 0..9 output words; the back end emits one
//   output word per cycle while the receiver is ready, so the output side
//   sets the sustained rate. The front end takes one input word per cycle
//   while the 4-entry job queue has room; the first result passes through
//   the queue write, the job load and the output register.
//   Reset (rst, synchronous) empties the queue and output stage, returns
//   the sequencer to idle and sets page_shift to 11.
//   When the receiver stalls, the output word holds, the back end waits,
//   the queue fills and then s_tready drops.
//   page_shift lives at APB address 0; write only while idle.
module spi_nand_read_sequencer (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // start_offset[31:0], byte_count[63:32], rx_byte[71:64]
  input  logic        s_tuser,   // command
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // tx_byte[7:0], data_byte[15:8], bytes_done[47:16]
  output logic [2:0]  m_tuser,   // action
  output logic        m_tlast,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic           [3:0] page_shift;
  logic                 q_push, q_full, q_pop, q_valid;
  snrs_pkg::job_t       push_job, pop_job;

  // register 0 at byte address 0; address bit 2 selects beyond the list
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {28'd0, page_shift} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      page_shift <= snrs_pkg::PAGE_SHIFT_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      page_shift <= pwdata[3:0];
    end
  end

  snrs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .page_shift (page_shift),
    .q_push     (q_push),
    .q_job      (push_job),
    .q_full     (q_full)
  );

  snrs_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .q_valid  (q_valid),
    .q_job    (pop_job)
  );

  snrs_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_job    (pop_job),
    .pop      (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

>>> hw/rtl/snrs_checker.sv
// Port-level checker for the SPI NAND read sequencer, bound to the top level.
// Depends on snrs_pkg and spi_nand_read_sequencer_assert.svh.
`include "spi_nand_read_sequencer_assert.svh"

module snrs_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata,
  input logic [2:0]  m_tuser,
  input logic        m_tlast
);

  // stalled output word holds
  `SNRS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "output word changed while stalled")

  // every word group ends on a clock-in or a finished report
  `SNRS_ASSERT_NOW(a_last_kind, m_tvalid && m_tlast, m_tuser == snrs_pkg::ACT_CLOCK || m_tuser == snrs_pkg::ACT_DONE, "last word is not clock or done")

  // finished report always closes its word group
  `SNRS_ASSERT_NOW(a_done_last, m_tvalid && m_tuser == snrs_pkg::ACT_DONE, m_tlast, "done word not marked last")

  // clock-in shifts out the fill byte
  `SNRS_ASSERT_NOW(a_clock_fill, m_tvalid && m_tuser == snrs_pkg::ACT_CLOCK, m_tdata[7:0] == snrs_pkg::FILL_BYTE, "clock word without fill byte")

endmodule

bind spi_nand_read_sequencer snrs_checker u_snrs_checker (.*);
